// File: design/skct_pkg.sv
// shared types and constants of the session key counter table
package skct_pkg;

  localparam int ID_W       = 8;
  localparam int LEN_W      = 16;
  localparam int WORD_W     = 64;
  localparam int KIND_W     = 2;
  localparam int OUTC_W     = 2;
  localparam int STEP_SHIFT = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_FREEZE = 2'd2,
    KIND_PACKET = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_FROZEN = 2'd2
  } status_t;

  typedef enum logic [OUTC_W-1:0] {
    OUT_NONE = 2'd0,
    OUT_DROP = 2'd1,
    OUT_KEY  = 2'd2
  } outcome_t;

  // hi and lo form the big-endian 128-bit counter
  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] tail_a;
    logic [WORD_W-1:0] tail_b;
  } key_t;

  // one table write request
  typedef struct packed {
    logic    stat_we;
    status_t stat;
    logic    key_we;
    key_t    key;
  } tbl_wr_t;

endpackage

// File: design/skct_in_if.sv
// request channel: one table command or data packet descriptor per transfer
interface skct_in_if;
  logic                          valid;
  logic                          ready;
  logic [skct_pkg::KIND_W-1:0]   kind;
  logic [skct_pkg::ID_W-1:0]     source_conn;
  logic [skct_pkg::ID_W-1:0]     dest_conn;
  logic [skct_pkg::WORD_W-1:0]   key_word0;
  logic [skct_pkg::WORD_W-1:0]   key_word1;
  logic [skct_pkg::WORD_W-1:0]   key_word2;
  logic [skct_pkg::WORD_W-1:0]   key_word3;
  logic [skct_pkg::LEN_W-1:0]    payload_length;

  modport source (
    output valid, kind, source_conn, dest_conn,
    output key_word0, key_word1, key_word2, key_word3, payload_length,
    input  ready
  );

  modport sink (
    input  valid, kind, source_conn, dest_conn,
    input  key_word0, key_word1, key_word2, key_word3, payload_length,
    output ready
  );
endinterface

// File: design/skct_out_if.sv
// result channel: outcome and attached key per transfer
interface skct_out_if;
  logic                          valid;
  logic                          ready;
  logic [skct_pkg::OUTC_W-1:0]   outcome;
  logic [skct_pkg::WORD_W-1:0]   out_key0;
  logic [skct_pkg::WORD_W-1:0]   out_key1;
  logic [skct_pkg::WORD_W-1:0]   out_key2;
  logic [skct_pkg::WORD_W-1:0]   out_key3;

  modport source (
    output valid, outcome, out_key0, out_key1, out_key2, out_key3,
    input  ready
  );

  modport sink (
    input  valid, outcome, out_key0, out_key1, out_key2, out_key3,
    output ready
  );
endinterface

// File: design/session_key_counter_table.sv
// session key counter table top level: handshake, item and result registers
//
// Direct-indexed table of 2**CONN_ID_BITS connection slots, each with a status
// (empty, active, frozen) and a 256-bit key whose first 128 bits are a
// big-endian counter. Open, close and freeze act on the source slot; a data
// packet looks up its destination slot and, when active, gets the current key
// attached while the counter advances by payload_length >> 4. Every request
// transfer yields exactly one result transfer, in order. One request is taken
// per clock while no result waits. A request's slot is read at its transfer
// edge; decode and counter update then move the item from the item register
// into the result register as soon as the result register is free or drains.
// A result that waits for out_ch.ready holds the next item in the item register,
// and the request channel stalls behind it. The read-modify-write of one slot
// per cycle is covered by forwarding, so back-to-back requests to the same slot
// see each other's updates. After reset, a clearing pass empties the status
// memory one slot per cycle, so in_ch.ready stays low until every slot has
// been cleared.
module session_key_counter_table #(
  parameter int CONN_ID_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  skct_in_if.sink        in_ch,
  skct_out_if.source     out_ch
);

  // item register, holds the request while its slot read completes
  logic                               s1_valid_r;
  skct_pkg::kind_t                    s1_kind_r;
  logic [skct_pkg::ID_W-1:0]          s1_src_r;
  logic [skct_pkg::ID_W-1:0]          s1_dst_r;
  skct_pkg::key_t                     s1_key_r;
  logic [skct_pkg::LEN_W-1:0]         s1_len_r;

  // result register
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  skct_pkg::outcome_t                 out_outcome_r;
  skct_pkg::key_t                     out_key_r;

  logic                               s1_go;
  logic                               in_fire;
  logic                               clr_busy;
  skct_pkg::status_t                  rd_stat;
  skct_pkg::key_t                     rd_key;
  skct_pkg::outcome_t                 upd_outcome;
  skct_pkg::key_t                     upd_key;
  skct_pkg::tbl_wr_t                  upd_wr;
  logic [CONN_ID_BITS-1:0]            upd_wr_addr;
  skct_pkg::key_t                     in_key;

  // item leaves the item register when the result register is free or drains
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clr_busy && (!s1_valid_r || s1_go);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_key.hi     = in_ch.key_word0;
  assign in_key.lo     = in_ch.key_word1;
  assign in_key.tail_a = in_ch.key_word2;
  assign in_key.tail_b = in_ch.key_word3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= skct_pkg::kind_t'(in_ch.kind);
      s1_src_r  <= in_ch.source_conn;
      s1_dst_r  <= in_ch.dest_conn;
      s1_key_r  <= in_key;
      s1_len_r  <= in_ch.payload_length;
    end
  end

  // slot memories, read on the request transfer, written as the item moves on
  skct_mem #(
    .AW (CONN_ID_BITS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_id    (in_ch.dest_conn),
    .wr       (upd_wr),
    .wr_addr  (upd_wr_addr),
    .rd_stat  (rd_stat),
    .rd_key   (rd_key),
    .clr_busy (clr_busy)
  );

  skct_update #(
    .AW (CONN_ID_BITS)
  ) u_update (
    .en      (s1_go),
    .kind    (s1_kind_r),
    .src     (s1_src_r),
    .dst     (s1_dst_r),
    .key_in  (s1_key_r),
    .len     (s1_len_r),
    .rd_stat (rd_stat),
    .rd_key  (rd_key),
    .outcome (upd_outcome),
    .res_key (upd_key),
    .wr      (upd_wr),
    .wr_addr (upd_wr_addr)
  );

  // result register, holds a finished result until its transfer
  assign out_valid_nxt = s1_go || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_outcome_r <= upd_outcome;
      out_key_r     <= upd_key;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.outcome  = out_outcome_r;
  assign out_ch.out_key0 = out_key_r.hi;
  assign out_ch.out_key1 = out_key_r.lo;
  assign out_ch.out_key2 = out_key_r.tail_a;
  assign out_ch.out_key3 = out_key_r.tail_b;

  // a stalled item keeps its slot and holds back new requests
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_dst_r) && !$past(in_fire)))
    else $error("item register changed while stalled");

  // table is written only when the item moves into the result register
  a_wr_on_go: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_wr.stat_we || upd_wr.key_we) |-> (s1_go && !clr_busy))
    else $error("table write without item advance");

  // no key leaks out unless a key is attached
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r != skct_pkg::OUT_KEY)) |->
      (out_key_r == '0))
    else $error("key on result without attached key");

  // an accepted request always lands in the item register
  a_fire_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted request lost");

endmodule

// File: design/skct_mem.sv
// slot status and key memories with clearing pass and write-to-read forwarding
module skct_mem #(
  parameter int AW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [skct_pkg::ID_W-1:0]   rd_id,
  input  skct_pkg::tbl_wr_t           wr,
  input  logic [AW-1:0]               wr_addr,
  output skct_pkg::status_t           rd_stat,
  output skct_pkg::key_t              rd_key,
  output logic                        clr_busy
);

  localparam int Depth = 1 << AW;
  localparam int ExtW  = (AW > skct_pkg::ID_W) ? AW : skct_pkg::ID_W;

  skct_pkg::status_t stat_mem [Depth];
  skct_pkg::key_t    key_mem  [Depth];

  logic [ExtW-1:0]   rd_ext;
  logic [AW-1:0]     rd_addr;

  skct_pkg::status_t stat_rd_r;
  skct_pkg::key_t    key_rd_r;
  logic              fwd_stat_r;
  logic              fwd_key_r;
  skct_pkg::status_t fwd_stat_d_r;
  skct_pkg::key_t    fwd_key_d_r;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_addr_r;

  assign rd_ext  = ExtW'(rd_id);
  assign rd_addr = rd_ext[AW-1:0];

  // clearing pass over the status memory after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      stat_mem[clr_addr_r] <= skct_pkg::ST_EMPTY;
    end else if (wr.stat_we) begin
      stat_mem[wr_addr] <= wr.stat;
    end
    if (rd_en) begin
      stat_rd_r <= stat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr.key;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[rd_addr];
    end
  end

  // a write in the same cycle as the read of that entry is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_stat_r <= 1'b0;
      fwd_key_r  <= 1'b0;
    end else if (rd_en) begin
      fwd_stat_r <= wr.stat_we && (wr_addr == rd_addr);
      fwd_key_r  <= wr.key_we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_stat_d_r <= wr.stat;
      fwd_key_d_r  <= wr.key;
    end
  end

  assign rd_stat  = fwd_stat_r ? fwd_stat_d_r : stat_rd_r;
  assign rd_key   = fwd_key_r ? fwd_key_d_r : key_rd_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: design/skct_update.sv
// command decode, key lookup result and counter advance for one item
module skct_update #(
  parameter int AW = 8
) (
  input  logic                        en,
  input  skct_pkg::kind_t             kind,
  input  logic [skct_pkg::ID_W-1:0]   src,
  input  logic [skct_pkg::ID_W-1:0]   dst,
  input  skct_pkg::key_t              key_in,
  input  logic [skct_pkg::LEN_W-1:0]  len,
  input  skct_pkg::status_t           rd_stat,
  input  skct_pkg::key_t              rd_key,
  output skct_pkg::outcome_t          outcome,
  output skct_pkg::key_t              res_key,
  output skct_pkg::tbl_wr_t           wr,
  output logic [AW-1:0]               wr_addr
);

  localparam int ExtW = (AW > skct_pkg::ID_W) ? AW : skct_pkg::ID_W;

  logic [ExtW-1:0]             src_ext;
  logic [ExtW-1:0]             dst_ext;
  logic [skct_pkg::WORD_W:0]   lo_sum;
  skct_pkg::tbl_wr_t           wr_raw;

  assign src_ext = ExtW'(src);
  assign dst_ext = ExtW'(dst);
  assign wr_addr = (kind == skct_pkg::KIND_PACKET) ? dst_ext[AW-1:0] : src_ext[AW-1:0];

  // low counter word plus step, top bit is the carry into the high word
  assign lo_sum = {1'b0, rd_key.lo} + (skct_pkg::WORD_W + 1)'(len >> skct_pkg::STEP_SHIFT);

  always_comb begin
    outcome = skct_pkg::OUT_NONE;
    res_key = '0;
    wr_raw  = '0;
    unique case (kind)
      skct_pkg::KIND_OPEN: begin
        if (src == dst) begin
          wr_raw.stat_we = 1'b1;
          wr_raw.stat    = skct_pkg::ST_ACTIVE;
          wr_raw.key_we  = 1'b1;
          wr_raw.key     = key_in;
        end
      end
      skct_pkg::KIND_CLOSE: begin
        wr_raw.stat_we = 1'b1;
        wr_raw.stat    = skct_pkg::ST_EMPTY;
      end
      skct_pkg::KIND_FREEZE: begin
        wr_raw.stat_we = 1'b1;
        wr_raw.stat    = skct_pkg::ST_FROZEN;
      end
      skct_pkg::KIND_PACKET: begin
        case (rd_stat)
          skct_pkg::ST_FROZEN: begin
            outcome = skct_pkg::OUT_DROP;
          end
          skct_pkg::ST_ACTIVE: begin
            outcome          = skct_pkg::OUT_KEY;
            res_key          = rd_key;
            wr_raw.key_we    = 1'b1;
            wr_raw.key       = rd_key;
            wr_raw.key.lo    = lo_sum[skct_pkg::WORD_W-1:0];
            wr_raw.key.hi    = rd_key.hi + skct_pkg::WORD_W'(lo_sum[skct_pkg::WORD_W]);
          end
          default: begin
            outcome = skct_pkg::OUT_NONE;
          end
        endcase
      end
      default: begin
        outcome = skct_pkg::OUT_NONE;
      end
    endcase
  end

  always_comb begin
    wr         = wr_raw;
    wr.stat_we = wr_raw.stat_we & en;
    wr.key_we  = wr_raw.key_we & en;
  end

endmodule
